>>> hw/rtl/ple_pkg.sv
package ple_pkg;

  typedef enum logic [2:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_BACK  = 3'd1,
    REQ_INS_POS   = 3'd2,
    REQ_DEL_FRONT = 3'd3,
    REQ_DEL_BACK  = 3'd4,
    REQ_DEL_POS   = 3'd5,
    REQ_DUMP      = 3'd6,
    REQ_RSVD      = 3'd7
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2,
    ST_RSVD    = 2'd3
  } status_e;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned PosW    = 6;
  localparam int unsigned CountW  = 6;
  localparam int unsigned InDataW = 48;
  localparam int unsigned OutDataW = 40;

endpackage

>>> hw/rtl/ple_node_mem.sv
// Node store: value and link arrays, one registered read port, one write port each.
module ple_node_mem #(
  parameter int unsigned AW = 5,
  parameter int unsigned DW = 32
) (
  input  logic          clk_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_val_o,
  output logic [AW-1:0] rd_next_o,
  output logic [AW-1:0] rd_prev_o,
  input  logic          val_we_i,
  input  logic [AW-1:0] val_addr_i,
  input  logic [DW-1:0] val_wdata_i,
  input  logic          next_we_i,
  input  logic [AW-1:0] next_addr_i,
  input  logic [AW-1:0] next_wdata_i,
  input  logic          prev_we_i,
  input  logic [AW-1:0] prev_addr_i,
  input  logic [AW-1:0] prev_wdata_i
);
  localparam int unsigned Depth = 1 << AW;
  logic [DW-1:0] val_mem  [Depth];
  logic [AW-1:0] next_mem [Depth];
  logic [AW-1:0] prev_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (val_we_i) val_mem[val_addr_i] <= val_wdata_i;
    if (next_we_i) next_mem[next_addr_i] <= next_wdata_i;
    if (prev_we_i) prev_mem[prev_addr_i] <= prev_wdata_i;
    rd_val_o  <= val_mem[rd_addr_i];
    rd_next_o <= next_mem[rd_addr_i];
    rd_prev_o <= prev_mem[rd_addr_i];
  end
endmodule

>>> hw/rtl/positional_list_engine_unit.sv
// Sequence: end inserts and refused or ignored requests answer from S_EXEC,
//   deletes pass S_WALK first, an insert at position p passes S_WALK then S_LINK.
// Dump: first result from S_DUMP, then one per cycle while the output is not stalled.
// Throughput: one request at a time, the next accepted in S_IDLE after its last result.
// Reset: rst_ni async low clears count, head, tail and control, and marks every slot free.
module positional_list_engine_unit #(
  parameter int unsigned CAPACITY   = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [2:0] req_type, [34:3] value, [40:35] position, rest zero
  input  logic [ple_pkg::InDataW-1:0]     s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [1:0] status, [7:2] count, [39:8] data, sign-extended
  output logic [ple_pkg::OutDataW-1:0]    m_axis_tdata_o,
  // [0] data_valid
  output logic                            m_axis_tuser_o,
  output logic                            m_axis_tlast_o
);
  import ple_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // S_EXEC decides the request, S_WALK follows next links one read per cycle,
  // S_LINK finishes the second half of a positional insert, S_DUMP streams values.
  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_WALK, S_LINK, S_DUMP
  } state_e;

  state_e                state_q, state_d;
  req_e                  req_q, req_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [PosW-1:0]       pos_q, pos_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [AW-1:0]         head_q, head_d;
  logic [AW-1:0]         tail_q, tail_d;
  logic [CAPACITY-1:0]   free_q, free_d;
  logic [AW-1:0]         cur_q, cur_d;    // slot whose data sits on the read port
  logic [CW-1:0]         idx_q, idx_d;    // 1-based list position of cur_q, counted from the tail for back deletes
  logic [AW-1:0]         slot_q, slot_d;  // new slot of a positional insert
  logic [AW-1:0]         bef_q, bef_d;    // its predecessor

  // output register
  logic                  ovalid_q, ovalid_d;
  status_e               ost_q, ost_d;
  logic [CountW-1:0]     ocnt_q, ocnt_d;
  logic [DATA_WIDTH-1:0] odata_q, odata_d;
  logic                  odv_q, odv_d;
  logic                  olast_q, olast_d;

  // memory ports
  logic [AW-1:0] rd_addr;
  logic [DATA_WIDTH-1:0] rd_val;
  logic [AW-1:0] rd_next, rd_prev;
  logic va_we, nx_we, pv_we;
  logic [AW-1:0] va_a, nx_a, nx_d, pv_a, pv_d;

  ple_node_mem #(.AW(AW), .DW(DATA_WIDTH)) u_mem (
    .clk_i, .rd_addr_i(rd_addr), .rd_val_o(rd_val), .rd_next_o(rd_next),
    .rd_prev_o(rd_prev), .val_we_i(va_we), .val_addr_i(va_a), .val_wdata_i(val_q),
    .next_we_i(nx_we), .next_addr_i(nx_a), .next_wdata_i(nx_d),
    .prev_we_i(pv_we), .prev_addr_i(pv_a), .prev_wdata_i(pv_d)
  );

  // lowest free slot
  logic [AW-1:0] free_slot;
  always_comb begin
    free_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_q[i]) free_slot = AW'(i);
    end
  end

  logic full, empty;
  assign full  = (cnt_q == CW'(CAPACITY));
  assign empty = (cnt_q == '0);

  logic [PosW:0] pos_x, cnt_x, cnt_x1;
  assign pos_x  = {1'b0, pos_q};
  assign cnt_x  = (PosW + 1)'(cnt_q);
  assign cnt_x1 = cnt_x + (PosW + 1)'(1);

  logic at_tgt, dump_end, back_sel;
  assign at_tgt   = ((PosW + 1)'(idx_q) == pos_x);
  assign dump_end = (idx_q == cnt_q);
  // deletes at the back start from the tail instead of walking
  assign back_sel = (req_q == REQ_DEL_BACK) || (req_q == REQ_DEL_POS && pos_x == cnt_x);

  logic out_free;
  assign out_free = !ovalid_q || m_axis_tready_i;
  // a new request may wait in S_EXEC while the previous result drains
  assign s_axis_tready_o = (state_q == S_IDLE);

  logic [DATA_WIDTH-1:0] in_val;
  assign in_val = DATA_WIDTH'($signed(s_axis_tdata_i[34:3]));

  logic                  emit, emit_dv, emit_last;
  status_e               emit_st;
  logic [DATA_WIDTH-1:0] emit_data;
  logic                  ins_front, ins_back;

  always_comb begin
    state_d = state_q; req_d = req_q; val_d = val_q; pos_d = pos_q;
    cnt_d = cnt_q; head_d = head_q; tail_d = tail_q; free_d = free_q;
    cur_d = cur_q; idx_d = idx_q; slot_d = slot_q; bef_d = bef_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;
    ost_d = ost_q; ocnt_d = ocnt_q; odata_d = odata_q; odv_d = odv_q; olast_d = olast_q;
    emit = 1'b0; emit_st = ST_DONE; emit_data = '0; emit_dv = 1'b0; emit_last = 1'b1;
    ins_front = 1'b0; ins_back = 1'b0;
    // hold the read on cur_q unless S_EXEC or a walk or dump step moves on
    rd_addr = cur_q;
    va_we = 1'b0; va_a = free_slot;
    nx_we = 1'b0; nx_a = free_slot; nx_d = '0;
    pv_we = 1'b0; pv_a = free_slot; pv_d = '0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          req_d   = req_e'(s_axis_tdata_i[2:0]);
          val_d   = in_val;
          pos_d   = s_axis_tdata_i[40:35];
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        rd_addr = back_sel ? tail_q : head_q;
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          cur_d   = rd_addr;
          idx_d   = CW'(1);
          case (req_q)
            REQ_INS_FRONT: begin
              if (full) emit_st = ST_FULL;
              else ins_front = 1'b1;
            end
            REQ_INS_BACK: begin
              if (full) emit_st = ST_FULL;
              else ins_back = 1'b1;
            end
            REQ_INS_POS: begin
              // range is checked before fullness
              if (pos_x == '0 || pos_x > cnt_x1) emit_st = ST_IGNORED;
              else if (full) emit_st = ST_FULL;
              else if (pos_x == (PosW + 1)'(1)) ins_front = 1'b1;
              else if (pos_x == cnt_x1) ins_back = 1'b1;
              else begin
                emit    = 1'b0;
                state_d = S_WALK;
              end
            end
            REQ_DEL_FRONT, REQ_DEL_BACK: begin
              if (empty) emit_st = ST_IGNORED;
              else begin
                emit    = 1'b0;
                state_d = S_WALK;
                pos_d   = PosW'(1);
              end
            end
            REQ_DEL_POS: begin
              if (pos_x == '0 || pos_x > cnt_x) emit_st = ST_IGNORED;
              else begin
                emit    = 1'b0;
                state_d = S_WALK;
                if (pos_x == cnt_x) begin
                  req_d = REQ_DEL_BACK;
                  pos_d = PosW'(1);
                end else if (pos_x == (PosW + 1)'(1)) begin
                  req_d = REQ_DEL_FRONT;
                end
              end
            end
            REQ_DUMP: begin
              // empty dump answers with one plain result
              if (!empty) begin
                emit    = 1'b0;
                state_d = S_DUMP;
              end
            end
            default: emit_st = ST_IGNORED;
          endcase
          // end inserts need no read: value and, unless the list is empty, both links written at once
          if (ins_front || ins_back) begin
            va_we = 1'b1;
            free_d[free_slot] = 1'b0;
            cnt_d = cnt_q + CW'(1);
            if (empty) begin
              head_d = free_slot;
              tail_d = free_slot;
            end else if (ins_front) begin
              nx_we = 1'b1; nx_a = free_slot; nx_d = head_q;
              pv_we = 1'b1; pv_a = head_q;    pv_d = free_slot;
              head_d = free_slot;
            end else begin
              pv_we = 1'b1; pv_a = free_slot; pv_d = tail_q;
              nx_we = 1'b1; nx_a = tail_q;    nx_d = free_slot;
              tail_d = free_slot;
            end
          end
        end
      end
      S_WALK: begin
        if (!at_tgt) begin
          rd_addr = rd_next;
          cur_d   = rd_next;
          idx_d   = idx_q + CW'(1);
        end else if (req_q == REQ_INS_POS) begin
          // new node goes in front of cur_q; its own entries first
          va_we = 1'b1;
          nx_we = 1'b1; nx_a = free_slot; nx_d = cur_q;
          pv_we = 1'b1; pv_a = free_slot; pv_d = rd_prev;
          slot_d  = free_slot;
          bef_d   = rd_prev;
          state_d = S_LINK;
        end else if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          free_d[cur_q] = 1'b1;
          cnt_d = cnt_q - CW'(1);
          case (req_q)
            REQ_DEL_FRONT: begin
              if (cnt_q > CW'(1)) head_d = rd_next;
            end
            REQ_DEL_BACK: begin
              if (cnt_q > CW'(1)) tail_d = rd_prev;
            end
            default: begin
              // inner delete: splice neighbors together
              nx_we = 1'b1; nx_a = rd_prev; nx_d = rd_next;
              pv_we = 1'b1; pv_a = rd_next; pv_d = rd_prev;
            end
          endcase
        end
      end
      S_LINK: begin
        if (out_free) begin
          nx_we = 1'b1; nx_a = bef_q; nx_d = slot_q;
          pv_we = 1'b1; pv_a = cur_q; pv_d = slot_q;
          free_d[slot_q] = 1'b0;
          cnt_d   = cnt_q + CW'(1);
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_dv   = 1'b1;
          emit_data = rd_val;
          emit_last = dump_end;
          if (dump_end) begin
            state_d = S_IDLE;
          end else begin
            rd_addr = rd_next;
            cur_d   = rd_next;
            idx_d   = idx_q + CW'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (emit) begin
      ovalid_d = 1'b1;
      ost_d    = emit_st;
      ocnt_d   = CountW'(cnt_d);
      odata_d  = emit_data;
      odv_d    = emit_dv;
      olast_d  = emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      req_q    <= REQ_INS_FRONT;
      val_q    <= '0;
      pos_q    <= '0;
      cnt_q    <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      free_q   <= '1;
      cur_q    <= '0;
      idx_q    <= '0;
      slot_q   <= '0;
      bef_q    <= '0;
      ovalid_q <= 1'b0;
      ost_q    <= ST_DONE;
      ocnt_q   <= '0;
      odata_q  <= '0;
      odv_q    <= 1'b0;
      olast_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      req_q    <= req_d;
      val_q    <= val_d;
      pos_q    <= pos_d;
      cnt_q    <= cnt_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      free_q   <= free_d;
      cur_q    <= cur_d;
      idx_q    <= idx_d;
      slot_q   <= slot_d;
      bef_q    <= bef_d;
      ovalid_q <= ovalid_d;
      ost_q    <= ost_d;
      ocnt_q   <= ocnt_d;
      odata_q  <= odata_d;
      odv_q    <= odv_d;
      olast_q  <= olast_d;
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {ValueW'($signed(odata_q)), ocnt_q, ost_q};
  assign m_axis_tuser_o  = odv_q;
  assign m_axis_tlast_o  = olast_q;
endmodule
